/* rtl/core/apq_pkg.sv */
package apq_pkg;

  // Queue geometry
  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned OccW     = 7;
  localparam int unsigned DataW    = 32;

  // Request codes; code 3 falls into the default arm and is ignored
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_PEEK    = 2'd1,
    OP_DEQUEUE = 2'd2
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One stored entry
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    enq_write;
    logic    scan_start;
    logic    scan_step;
    logic    shift_start;
    logic    shift_step;
    logic    cnt_dec;
    logic    res_load;
    status_e res_status;
    logic    res_best;
    logic    res_occ_inc;
    logic    res_occ_dec;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic ptr_at_end;
    logic shift_none;
  } stat_t;

endpackage

/* rtl/core/apq_datapath.sv */
module apq_datapath import apq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  input  logic signed [DataW-1:0] item_value_i,
  input  logic signed [DataW-1:0] item_priority_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] best_value_o,
  output logic signed [DataW-1:0] best_priority_o,
  output logic [OccW-1:0]         occupancy_o
);

  // Entry store, one write and one registered read port
  entry_t            mem [Capacity];
  entry_t            rd_q;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  entry_t            wr_data;
  logic              wr_en;

  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [AddrW-1:0]  best_idx_q, best_idx_d;
  entry_t            best_q, best_d;
  logic              take;

  logic              res_valid_q;
  status_e           res_status_q;
  entry_t            res_best_q;
  logic [OccW-1:0]   res_occ_q;
  logic [CntW-1:0]   occ_next;
  logic [CntW-1:0]   best_next;

  // Status towards the controller
  assign best_next = CntW'(best_idx_q) + CntW'(1);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q >= CntW'(Capacity));
  assign stat_o.ptr_at_end = (ptr_q == count_q);
  assign stat_o.shift_none = (best_next == count_q);

  // Read address: scan and shift walk the pointer, starts prime the first read
  always_comb begin
    rd_addr = ptr_q[AddrW-1:0];
    if (cmd_i.scan_start) begin
      rd_addr = '0;
    end else if (cmd_i.shift_start) begin
      rd_addr = best_next[AddrW-1:0];
    end
  end

  // Write port: append on enqueue, move one place down while shifting
  always_comb begin
    wr_en   = cmd_i.enq_write | cmd_i.shift_step;
    wr_addr = count_q[AddrW-1:0];
    wr_data = '{value: item_value_i, prio: item_priority_i};
    if (cmd_i.shift_step) begin
      wr_addr = AddrW'(ptr_q - CntW'(2));
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Comparison of the entry just read against the best so far
  always_comb begin
    take = (ptr_q == CntW'(1))
        || (rd_q.prio > best_q.prio)
        || ((rd_q.prio == best_q.prio) && (rd_q.value > best_q.value));
  end

  // Pointer, count and best-entry registers
  always_comb begin
    ptr_d      = ptr_q;
    count_d    = count_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    if (cmd_i.scan_start) begin
      ptr_d = CntW'(1);
    end else if (cmd_i.shift_start) begin
      ptr_d = best_next + CntW'(1);
    end else if (cmd_i.scan_step || cmd_i.shift_step) begin
      ptr_d = ptr_q + CntW'(1);
    end
    if (cmd_i.scan_step && take) begin
      best_d     = rd_q;
      best_idx_d = AddrW'(ptr_q - CntW'(1));
    end
    if (cmd_i.enq_write) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  // Result register: shown for one cycle after each load
  always_comb begin
    occ_next = count_q;
    if (cmd_i.res_occ_inc) begin
      occ_next = count_q + CntW'(1);
    end else if (cmd_i.res_occ_dec) begin
      occ_next = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_best_q   <= cmd_i.res_best ? best_q : '0;
      res_occ_q    <= OccW'(occ_next);
    end
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign best_value_o    = res_best_q.value;
  assign best_priority_o = res_best_q.prio;
  assign occupancy_o     = res_occ_q;

  // The fill level never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  // An append only happens with room left, and raises the count by one
  a_enq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq_write |-> !stat_o.full ##1 (count_q == $past(count_q) + CntW'(1)))
    else $error("append without room or count not advanced");

  // A scan step compares an entry that is held
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (ptr_q >= CntW'(1)) && (ptr_q <= count_q))
    else $error("scan pointer outside held entries");

  // A shift step moves an entry that is held into the place below it
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_step |-> (ptr_q >= CntW'(2)) && (ptr_q <= count_q))
    else $error("shift pointer outside held entries");

endmodule

/* rtl/core/apq_ctrl.sv */
module apq_ctrl import apq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] opcode_i,
  output logic       busy,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_REPORT = 4'b0100,
    S_SHIFT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   is_deq_q, is_deq_d;

  assign busy = (state_q != S_IDLE);

  // Sequencing of one request
  always_comb begin
    state_d  = state_q;
    is_deq_d = is_deq_q;
    cmd_o    = '0;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (opcode_e'(opcode_i)) inside
            OP_ENQUEUE: begin
              cmd_o.res_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.enq_write   = 1'b1;
                cmd_o.res_occ_inc = 1'b1;
              end
            end
            OP_PEEK, OP_DEQUEUE: begin
              if (stat_i.empty) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.scan_start = 1'b1;
                is_deq_d         = (opcode_e'(opcode_i) == OP_DEQUEUE);
                state_d          = S_SCAN;
              end
            end
            default: begin
              cmd_o.res_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.ptr_at_end) begin
          state_d = S_REPORT;
        end
      end
      S_REPORT: begin
        cmd_o.res_load    = 1'b1;
        cmd_o.res_best    = 1'b1;
        cmd_o.res_occ_dec = is_deq_q;
        if (!is_deq_q) begin
          state_d = S_IDLE;
        end else if (stat_i.shift_none) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.ptr_at_end) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      is_deq_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_deq_q <= is_deq_d;
    end
  end

  // A result is issued only when a request is taken or its scan completes
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (state_q == S_REPORT) || (state_q == S_IDLE && start))
    else $error("result issued outside a request");

  // Shifting only follows the report of a dequeue
  a_shift_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) && !$past(state_q == S_SHIFT) |-> $past(is_deq_q))
    else $error("shift entered without a dequeue");

endmodule

/* rtl/core/array_priority_queue_unit.sv */
// Channel   Transfer when             Signals
// request   start && !busy            opcode_i, item_value_i, item_priority_i
// result    result_valid_o            status_o, best_value_o, best_priority_o, occupancy_o
//
// Enqueue, ignored codes and requests on an empty queue answer in the cycle after they are taken.
// Peek reads each held entry from the store in turn, then reports the best one.
// After its result, a dequeue moves every entry above the index taken one place down while busy.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset empties the queue at once; stored entries are left as they are.
module array_priority_queue_unit import apq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode_i,
  input  logic signed [DataW-1:0] item_value_i,
  input  logic signed [DataW-1:0] item_priority_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] best_value_o,
  output logic signed [DataW-1:0] best_priority_o,
  output logic [OccW-1:0]         occupancy_o
);

  cmd_t  cmd;
  stat_t stat;

  // Request sequencing
  apq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .busy     (busy),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // Entry store, scan compare and result register
  apq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .best_value_o    (best_value_o),
    .best_priority_o (best_priority_o),
    .occupancy_o     (occupancy_o)
  );

endmodule
